[sv/odm_pkg.sv]
// Shared widths, codes and saturation helper for the occupied density matrix block.
`default_nettype none

package odm_pkg;

  localparam int KIND_W  = 2;
  localparam int IDX_W   = 6;
  localparam int LOAD_W  = 24;
  localparam int COEF_W  = 18;
  localparam int EIG_W   = 24;
  localparam int PROD_W  = 2 * COEF_W;        // c*c
  localparam int WPROD_W = PROD_W + EIG_W;    // c*c*e
  localparam int FRAC    = 15;
  localparam int TERM_W  = WPROD_W - FRAC;    // one accumulated term
  localparam int DENS_W  = 48;
  localparam int MAG_W   = 47;
  localparam int WIDE_W  = DENS_W + 2;        // headroom for add and scale
  localparam int CNT_W   = 7;                 // configuration counts
  localparam int CMP_W   = 12;                // common width for bound checks
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_COEF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_EIG  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW       = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_BASIS_COUNT    = 2'd0;
  localparam logic [1:0] REG_OCCUPIED_COUNT = 2'd1;
  localparam logic [1:0] REG_WEIGHTING_MODE = 2'd2;

  localparam logic [CNT_W-1:0] BASIS_COUNT_RESET = 7'd64;
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef logic signed [DENS_W-1:0] dens_t;

  // Clamp a wide signed value to the signed 48-bit range.
  function automatic dens_t sat_dens(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'({1'b0, {(DENS_W-1){1'b1}}});
    lo = -hi - WIDE_W'(1);
    if (x > hi) begin
      sat_dens = hi[DENS_W-1:0];
    end else if (x < lo) begin
      sat_dens = lo[DENS_W-1:0];
    end else begin
      sat_dens = x[DENS_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[sv/odm_if.sv]
// Valid/ready channel interfaces for load/row items and density results.
`default_nettype none

interface odm_in_if
  import odm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         column_index;
  logic signed [LOAD_W-1:0] load_value;

  modport source (output valid, kind, row_index, column_index, load_value, input ready);
  modport sink   (input valid, kind, row_index, column_index, load_value, output ready);
endinterface

interface odm_out_if
  import odm_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_column;
  logic signed [DENS_W-1:0] density_value;
  logic [MAG_W-1:0]         running_max;
  logic                     last_of_row;

  modport source (output valid, out_row, out_column, density_value, running_max,
                  last_of_row, input ready);
  modport sink   (input valid, out_row, out_column, density_value, running_max,
                  last_of_row, output ready);
endinterface

`default_nettype wire

[sv/occupied_density_matrix_top.sv]
// Top level of the occupied density matrix block: stores, MAC pipeline, sequencer.
//
//  channel  | dir | handshake        | beat
//  ---------+-----+------------------+------------------------------------------
//  items    | in  | valid/ready      | kind, row_index, column_index, load_value
//  results  | out | valid/ready      | out_row, out_column, density_value,
//           |     |                  | running_max, last_of_row
//  apb      | in  | psel/penable     | basis_count, occupied_count, weighting_mode
//
// A load beat writes the coefficient or eigenvalue memory directly.
// A row request for row i produces i+1 elements. For each element the sequencer issues
// no reads on the two coefficient read ports, where no is the clipped occupied count,
// then drains the multiply pipeline and moves the sum to the output register.
// Reset (rst, synchronous) clears control and the running maximum; both memories hold
// garbage until loaded. A stalled result beat holds the sequencer in drain; the next
// item is taken as soon as the last element of a row sits in the output register.
`default_nettype none

module occupied_density_matrix_top
  import odm_pkg::*;
#(
  parameter int MAX_BASIS    = 64,
  parameter int MAX_OCCUPIED = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  odm_in_if.sink                 items,
  odm_out_if.source              results,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output      logic [APB_DW-1:0] prdata,
  output      logic              pready
);

  // Memory geometry: row bits over column bits.
  localparam int RW  = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;
  localparam int CW  = (MAX_OCCUPIED > 1) ? $clog2(MAX_OCCUPIED) : 1;
  localparam int AW  = RW + CW;
  localparam int OCW = $clog2(MAX_OCCUPIED + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // ---------------- configuration registers ----------------
  logic [CNT_W-1:0] basis_count;
  logic [CNT_W-1:0] occupied_count;
  logic             weighting_mode;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_count    <= BASIS_COUNT_RESET;
      occupied_count <= '0;
      weighting_mode <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BASIS_COUNT:    basis_count    <= pwdata[CNT_W-1:0];
        REG_OCCUPIED_COUNT: occupied_count <= pwdata[CNT_W-1:0];
        REG_WEIGHTING_MODE: weighting_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BASIS_COUNT:    prdata = APB_DW'(basis_count);
      REG_OCCUPIED_COUNT: prdata = APB_DW'(occupied_count);
      REG_WEIGHTING_MODE: prdata = APB_DW'(weighting_mode);
      default:            prdata = '0;
    endcase
  end

  // Clip counts to the store dimensions.
  logic [CMP_W-1:0] nb;
  logic [OCW-1:0]   no;

  always_comb begin
    if (CMP_W'(basis_count) > CMP_W'(MAX_BASIS)) begin
      nb = CMP_W'(MAX_BASIS);
    end else begin
      nb = CMP_W'(basis_count);
    end
    if (CMP_W'(occupied_count) > CMP_W'(MAX_OCCUPIED)) begin
      no = OCW'(MAX_OCCUPIED);
    end else begin
      no = OCW'(occupied_count);
    end
  end

  // ---------------- sequencer state ----------------
  logic [1:0]       state;
  logic [RW-1:0]    row_r;
  logic [RW-1:0]    col_j;
  logic [OCW-1:0]   kc;
  logic             v1, v2, v3;
  logic             pipe_busy;
  logic             out_free;
  logic             fin;
  logic             in_acc;
  logic             row_ok;

  assign items.ready = (state == ST_IDLE);
  assign in_acc      = items.valid & items.ready;
  assign row_ok      = (items.kind == KIND_ROW) && (CMP_W'(items.row_index) < nb);
  assign pipe_busy   = v1 | v2 | v3;
  assign out_free    = ~results.valid | results.ready;
  assign fin         = (state == ST_DRAIN) & ~pipe_busy & out_free;

  // ---------------- memories ----------------
  logic signed [COEF_W-1:0] coef_mem [2**AW];
  logic signed [EIG_W-1:0]  eig_mem  [2**CW];
  logic signed [COEF_W-1:0] ca, cb;
  logic signed [EIG_W-1:0]  ev;
  logic                     coef_we, eig_we;
  logic [AW-1:0]            addr_a, addr_b;

  assign coef_we = in_acc && (items.kind == KIND_LOAD_COEF)
                   && (CMP_W'(items.row_index) < CMP_W'(MAX_BASIS))
                   && (CMP_W'(items.column_index) < CMP_W'(MAX_OCCUPIED));
  assign eig_we  = in_acc && (items.kind == KIND_LOAD_EIG)
                   && (CMP_W'(items.column_index) < CMP_W'(MAX_OCCUPIED));
  assign addr_a  = {row_r, kc[CW-1:0]};
  assign addr_b  = {col_j, kc[CW-1:0]};

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[{RW'(items.row_index), CW'(items.column_index)}] <=
        items.load_value[COEF_W-1:0];
    end
    if (eig_we) begin
      eig_mem[CW'(items.column_index)] <= items.load_value;
    end
    ca <= coef_mem[addr_a];
    cb <= coef_mem[addr_b];
    ev <= eig_mem[kc[CW-1:0]];
  end

  // ---------------- multiply-accumulate pipeline ----------------
  logic signed [PROD_W-1:0]  p1;
  logic signed [EIG_W-1:0]   e_d;
  logic signed [WPROD_W-1:0] wprod;
  logic signed [TERM_W-1:0]  term;
  logic signed [DENS_W-1:0]  acc;

  assign wprod = WPROD_W'(p1) * WPROD_W'(e_d);

  always_ff @(posedge clk) begin
    p1  <= PROD_W'(ca) * PROD_W'(cb);
    e_d <= ev;
    // Arithmetic shift floors toward minus infinity.
    term <= weighting_mode ? wprod[WPROD_W-1:FRAC] : TERM_W'(p1);
  end

  // ---------------- element finish: scale, magnitude, max ----------------
  logic signed [WIDE_W-1:0] acc_w;
  logic signed [WIDE_W-1:0] scaled_w;
  logic [MAG_W+1:0]         abs_v;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W-1:0]         largest;
  logic [MAG_W-1:0]         largest_next;

  always_comb begin
    acc_w    = WIDE_W'(acc);
    scaled_w = weighting_mode ? -(acc_w <<< 1) : (acc_w <<< 1);
    abs_v    = acc[DENS_W-1] ? (MAG_W+2)'(-acc_w) : (MAG_W+2)'(acc_w);
    mag      = (abs_v > (MAG_W+2)'(MAG_MAX)) ? MAG_MAX : abs_v[MAG_W-1:0];
    largest_next = (mag > largest) ? mag : largest;
  end

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      largest       <= '0;
      results.valid <= 1'b0;
      kc            <= '0;
      col_j         <= '0;
      row_r         <= '0;
      acc           <= '0;
    end else begin
      v1 <= (state == ST_ISSUE);
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        acc <= sat_dens(WIDE_W'(acc) + WIDE_W'(term));
      end

      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc && row_ok) begin
            row_r <= RW'(items.row_index);
            col_j <= '0;
            kc    <= '0;
            acc   <= '0;
            if (!weighting_mode && (items.row_index == '0)) begin
              largest <= '0;
            end
            state <= (no != '0) ? ST_ISSUE : ST_DRAIN;
          end
        end
        ST_ISSUE: begin
          kc <= kc + OCW'(1);
          if (kc == no - OCW'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (fin) begin
            results.valid <= 1'b1;
            acc           <= '0;
            kc            <= '0;
            if (!weighting_mode) begin
              largest <= largest_next;
            end
            if (col_j == row_r) begin
              state <= ST_IDLE;
            end else begin
              col_j <= col_j + RW'(1);
              state <= (no != '0) ? ST_ISSUE : ST_DRAIN;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (fin) begin
      results.out_row       <= IDX_W'(row_r);
      results.out_column    <= IDX_W'(col_j);
      results.density_value <= sat_dens(scaled_w);
      results.running_max   <= weighting_mode ? '0 : largest_next;
      results.last_of_row   <= (col_j == row_r);
    end
  end

  // ---------------- assertions ----------------
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pipe_busy)
    else $error("MAC pipeline busy while idle");

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (col_j <= row_r))
    else $error("column counter passed the row");

  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> (kc < no))
    else $error("column read beyond occupied count");

  a_fin_loads_output: assert property (@(posedge clk) disable iff (rst)
    fin |=> results.valid)
    else $error("finished element not presented");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the occupied density matrix block: stimulus, predictor, checks.

module tb_top;
  import odm_pkg::*;

  localparam int MAX_BASIS      = 64;
  localparam int MAX_OCCUPIED   = 64;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int CONFIG_SETTLE  = 16;   // lets an ignored beat or a load retire
  localparam int END_SETTLE     = 140;  // about two full elements at the largest occupied count
  localparam int SEQS_PER_PHASE = 8;
  localparam int NUM_PHASES     = 9;

  // Spare item code: the block has to swallow it without a result.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  localparam longint DENS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DENS_LO = -DENS_HI - 64'sd1;
  localparam longint MAG_TOP = 64'sh0000_7FFF_FFFF_FFFF;

  typedef enum int {FILL_RANDOM, FILL_TOP, FILL_BOTTOM, FILL_TINY} fill_style_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         column;
    logic signed [DENS_W-1:0] density;
    logic [MAG_W-1:0]         peak;
    logic                     last;
  } density_beat_t;

  // Mirror of the block: both stores, the running peak and the three registers.
  class density_scoreboard;
    logic signed [COEF_W-1:0] coef_mem [MAX_BASIS][MAX_OCCUPIED];
    logic signed [EIG_W-1:0]  eig_mem [MAX_OCCUPIED];
    logic [MAG_W-1:0]         peak_mag;
    logic [CNT_W-1:0]         basis_count;
    logic [CNT_W-1:0]         occupied_count;
    logic                     weighted;
    density_beat_t            expected_elements[$];
    int                       errors;

    function new();
      peak_mag       = '0;
      basis_count    = BASIS_COUNT_RESET;
      occupied_count = '0;
      weighted       = 1'b0;
      errors         = 0;
    endfunction

    function int rows_in_use();
      return (basis_count > MAX_BASIS) ? MAX_BASIS : int'(basis_count);
    endfunction

    function int cols_in_use();
      return (occupied_count > MAX_OCCUPIED) ? MAX_OCCUPIED : int'(occupied_count);
    endfunction

    function void configure(logic [1:0] index, logic [APB_DW-1:0] data);
      case (index)
        REG_BASIS_COUNT:    basis_count    = data[CNT_W-1:0];
        REG_OCCUPIED_COUNT: occupied_count = data[CNT_W-1:0];
        REG_WEIGHTING_MODE: weighted       = data[0];
        default: ;
      endcase
    endfunction

    function longint clamp48(longint x);
      if (x > DENS_HI) return DENS_HI;
      if (x < DENS_LO) return DENS_LO;
      return x;
    endfunction

    // Apply one accepted item; a row request queues its elements in emit order.
    function void accept_item(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] row,
                              logic [IDX_W-1:0] column, logic signed [LOAD_W-1:0] value);
      int            nb;
      int            no;
      longint        acc;
      longint        term;
      longint        scaled;
      longint        mag;
      density_beat_t beat;
      nb = rows_in_use();
      no = cols_in_use();
      case (kind)
        KIND_LOAD_COEF: coef_mem[row][column] = value[COEF_W-1:0];
        KIND_LOAD_EIG:  eig_mem[column] = value;
        KIND_ROW: begin
          if (row < nb) begin
            if (!weighted && row == 0) peak_mag = '0;
            for (int j = 0; j <= row; j++) begin
              acc = 0;
              for (int k = 0; k < no; k++) begin
                term = longint'(coef_mem[row][k]) * longint'(coef_mem[j][k]);
                if (weighted) term = (term * longint'(eig_mem[k])) >>> FRAC;
                acc = clamp48(acc + term);
              end
              scaled = clamp48(weighted ? -2 * acc : 2 * acc);
              if (!weighted) begin
                mag = (acc < 0) ? -acc : acc;
                if (mag > MAG_TOP) mag = MAG_TOP;
                if (mag > longint'(peak_mag)) peak_mag = mag[MAG_W-1:0];
              end
              beat.row     = row;
              beat.column  = j[IDX_W-1:0];
              beat.density = scaled[DENS_W-1:0];
              beat.peak    = weighted ? '0 : peak_mag;
              beat.last    = (j == row);
              expected_elements.push_back(beat);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_element(density_beat_t got);
      density_beat_t want;
      if (expected_elements.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, row %0d column %0d", $time, got.row,
                 got.column);
        return;
      end
      want = expected_elements.pop_front();
      check_field("out_row", want.row, got.row);
      check_field("out_column", want.column, got.column);
      check_field("density_value", want.density, got.density);
      check_field("running_max", want.peak, got.peak);
      check_field("last_of_row", want.last, got.last);
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  odm_in_if  items_ch ();
  odm_out_if results_ch ();

  occupied_density_matrix_top uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  density_scoreboard sb;

  // Which store entries hold a loaded value; a row request only goes out once
  // every entry it reads has been written.
  bit coef_loaded [MAX_BASIS][MAX_OCCUPIED];
  bit eig_loaded [MAX_OCCUPIED];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit holdoff_req    = 1'b0;
  int holdoff_left   = 0;
  int cycle_count    = 0;

  // Phase table: basis_count, occupied_count, weighting_mode. Values above the
  // store size and the zero corners are in here on purpose.
  int phase_basis [NUM_PHASES] = '{64, 64, 0, 127, 17, 64, 1, 40, 64};
  int phase_occ   [NUM_PHASES] = '{64, 3, 2, 100, 0, 5, 64, 4, 1};
  int phase_mode  [NUM_PHASES] = '{1, 0, 0, 0, 1, 1, 0, 0, 1};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold reset from the start, release on a falling edge, never assert again.
  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Result side: random stalls, or a long hold-off when the main flow asks.
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_req  = 1'b0;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Sample both channels on the rising edge; everything is driven on the falling one.
  always @(posedge clk) begin
    density_beat_t got;
    if (!rst) begin
      if (items_ch.valid && items_ch.ready) begin
        sb.accept_item(items_ch.kind, items_ch.row_index, items_ch.column_index,
                       items_ch.load_value);
      end
      if (results_ch.valid && results_ch.ready) begin
        got.row     = results_ch.out_row;
        got.column  = results_ch.out_column;
        got.density = results_ch.density_value;
        got.peak    = results_ch.running_max;
        got.last    = results_ch.last_of_row;
        sb.check_element(got);
      end
    end
  end

  // Watchdog: stop a hung run with a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: watchdog expired, %0d elements still outstanding", $time,
               sb.expected_elements.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default:   begin send_idle_pct = 9;  recv_stall_pct = 9;  end
    endcase
  endtask

  // Offer one item beat, with random idle cycles ahead of it, and hold it until taken.
  // Valid stays high afterwards: the next call or drain_results decides on the next edge.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] column, input logic [LOAD_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid        <= 1'b1;
    items_ch.kind         <= kind;
    items_ch.row_index    <= row;
    items_ch.column_index <= column;
    items_ch.load_value   <= value;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
  endtask

  task automatic load_coef(input int row, input int column, input logic [LOAD_W-1:0] value);
    coef_loaded[row][column] = 1'b1;
    send_item(KIND_LOAD_COEF, row[IDX_W-1:0], column[IDX_W-1:0], value);
  endtask

  // The row field of an eigenvalue load is don't-care; randomize it anyway.
  task automatic load_eig(input int column, input logic [LOAD_W-1:0] value);
    eig_loaded[column] = 1'b1;
    send_item(KIND_LOAD_EIG, IDX_W'($urandom()), column[IDX_W-1:0], value);
  endtask

  task automatic request_row(input int row);
    send_item(KIND_ROW, row[IDX_W-1:0], IDX_W'($urandom()), LOAD_W'($urandom()));
  endtask

  // Drop valid, wait out every queued element, then let the block settle.
  task automatic drain_results(input int settle);
    @(negedge clk) items_ch.valid <= 1'b0;
    while (sb.expected_elements.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] index, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(negedge clk) penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.configure(index, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Registers only change with the block idle. Upper data bits carry junk.
  task automatic set_config(input int basis, input int occ, input int mode);
    logic [APB_DW-1:0] data;
    drain_results(CONFIG_SETTLE);
    data = $urandom();
    data[CNT_W-1:0] = basis[CNT_W-1:0];
    apb_write(REG_BASIS_COUNT, data);
    data = $urandom();
    data[CNT_W-1:0] = occ[CNT_W-1:0];
    apb_write(REG_OCCUPIED_COUNT, data);
    data = $urandom();
    data[0] = mode[0];
    apb_write(REG_WEIGHTING_MODE, data);
  endtask

  // Top and bottom patterns push weighted sums into saturation at large occupied counts.
  function automatic logic [LOAD_W-1:0] coef_pattern(input fill_style_t style);
    case (style)
      FILL_TOP:    return 24'h01FFFF;
      FILL_BOTTOM: return $urandom_range(0, 1) ? 24'h020000 : 24'hFE0000;
      FILL_TINY:   return LOAD_W'($urandom_range(0, 128)) - 24'd64;
      default:     return LOAD_W'($urandom());
    endcase
  endfunction

  function automatic logic [LOAD_W-1:0] eig_pattern(input fill_style_t style);
    case (style)
      FILL_TOP:    return 24'h7FFFFF;
      FILL_BOTTOM: return 24'h800000;
      FILL_TINY:   return LOAD_W'($urandom_range(0, 128)) - 24'd64;
      default:     return LOAD_W'($urandom());
    endcase
  endfunction

  // One well-formed sequence: fill what the row will read, sprinkle noise, request it.
  task automatic row_sequence();
    int          nb;
    int          no;
    int          r;
    bit          refresh;
    fill_style_t style;
    nb      = sb.rows_in_use();
    no      = sb.cols_in_use();
    style   = fill_style_t'($urandom_range(0, 3));
    refresh = (style == FILL_TOP || style == FILL_BOTTOM) && ($urandom_range(0, 2) == 0);
    if (no > 8) begin
      r = $urandom_range(0, 1);
    end else begin
      case ($urandom_range(0, 9))
        0:       r = 63;
        1:       r = (nb == 0) ? $urandom_range(0, 3) : nb - $urandom_range(0, 1);
        default: r = $urandom_range(0, 7);
      endcase
    end
    if (r > 63) r = 63;
    if (r < nb) begin
      for (int j = 0; j <= r; j++) begin
        for (int k = 0; k < no; k++) begin
          if (refresh || !coef_loaded[j][k]) load_coef(j, k, coef_pattern(style));
        end
      end
      if (sb.weighted) begin
        for (int k = 0; k < no; k++) begin
          if (refresh || !eig_loaded[k]) load_eig(k, eig_pattern(style));
        end
      end
    end
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0: send_item(KIND_SPARE, IDX_W'($urandom()), IDX_W'($urandom()), LOAD_W'($urandom()));
        1: load_coef($urandom_range(0, 63), $urandom_range(0, 63), LOAD_W'($urandom()));
        2: load_eig($urandom_range(0, 63), LOAD_W'($urandom()));
        default: begin
          if (nb < MAX_BASIS) request_row($urandom_range(nb, 63));
        end
      endcase
    end
    request_row(r);
  endtask

  initial begin
    sb = new();
    items_ch.valid        = 1'b0;
    items_ch.kind         = KIND_LOAD_COEF;
    items_ch.row_index    = '0;
    items_ch.column_index = '0;
    items_ch.load_value   = '0;
    results_ch.ready      = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: field extremes, coefficient wrap, spare kind, both modes,
    // rejected row, zero occupied count, row zero restart of the peak.
    set_idle(IDLE_NONE);
    set_config(64, 2, 0);
    load_coef(0, 0, 24'h01FFFF);
    load_coef(0, 1, 24'hFE0000);   // wraps to the most negative coefficient
    load_coef(1, 0, 24'h7ABCDE);   // upper bits dropped
    load_coef(1, 1, 24'h020000);
    send_item(KIND_SPARE, 6'h3F, 6'h3F, 24'hFFFFFF);
    request_row(0);
    request_row(1);
    load_eig(0, 24'h7FFFFF);
    load_eig(1, 24'h800000);
    load_coef(63, 63, 24'h000001);
    set_config(64, 2, 1);
    request_row(1);
    request_row(0);                // weighted: peak neither restarts nor moves
    set_config(1, 2, 0);
    request_row(1);                // beyond basis_count, dropped
    request_row(0);
    set_config(64, 0, 0);
    request_row(1);
    request_row(0);

    // Random phases. Phase 1 holds off the result side to back up the input;
    // phase 5 stops sending mid-way until every element is back.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(phase_basis[p], phase_occ[p], phase_mode[p]);
      set_idle(idle_mode_t'(p % 4));
      for (int s = 0; s < SEQS_PER_PHASE; s++) begin
        if (p == 1 && s == 3) holdoff_req = 1'b1;
        if (p == 5 && s == 4) drain_results(CONFIG_SETTLE);
        row_sequence();
      end
    end

    drain_results(END_SETTLE);
    if (sb.errors == 0 && sb.expected_elements.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
